>>> hw/rtl/mnpc_pkg.sv
// ----------------------------------------------------------------------------
// mnpc_pkg
// Shared types and constants for the MIDI note pair capture unit.
// ----------------------------------------------------------------------------
package mnpc_pkg;

  localparam int OPEN_SLOTS = 64;
  localparam int SLOT_W     = $clog2(OPEN_SLOTS);
  localparam int COUNT_W    = $clog2(OPEN_SLOTS + 1);
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 18;

  localparam logic [2:0] FN_NOTE_ON   = 3'd0;
  localparam logic [2:0] FN_NOTE_OFF  = 3'd1;
  localparam logic [2:0] FN_ALL_OFF   = 3'd2;
  localparam logic [2:0] FN_TRANSPORT = 3'd3;
  localparam logic [2:0] FN_CLEAR     = 3'd4;

  localparam logic [2:0] REG_CAPTURE_ENABLE   = 3'd0;
  localparam logic [2:0] REG_NEW_TAKE_ON_PLAY = 3'd1;
  localparam logic [2:0] REG_ZONE_LOW         = 3'd2;
  localparam logic [2:0] REG_ZONE_HIGH        = 3'd3;
  localparam logic [2:0] REG_REWIND_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_CAPTURE_LIMIT    = 3'd5;

  typedef struct packed {
    logic [2:0]        func;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] block_end_time;
    logic              is_playing;
    logic [4:0]        midi_channel;
    logic [6:0]        note_number;
    logic [6:0]        note_velocity;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       out_channel;
    logic [6:0]       out_note;
    logic [6:0]       out_velocity;
    logic [31:0]      onset;
    logic [31:0]      release_res;
    logic             in_zone;
    logic [CNT_W-1:0] notes_so_far;
    logic [CNT_W-1:0] zone_notes_so_far;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [4:0]        channel;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic [TIME_W-1:0] on_time;
  } entry_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_WRITE,
    CH_SHIFT_INS,
    CH_SHIFT
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [SLOT_W-1:0] pos;
  } chain_ctl_t;

endpackage

>>> hw/rtl/mnpc_cell.sv
// ----------------------------------------------------------------------------
// mnpc_cell
// One slot of the open-note chain; loads from its neighbor or the insert bus.
// ----------------------------------------------------------------------------
module mnpc_cell (
  input  logic                      clk,
  input  mnpc_pkg::chain_ctl_t      ctl,
  input  logic [mnpc_pkg::SLOT_W-1:0] cell_idx,
  input  mnpc_pkg::entry_t          nbr_entry,
  input  mnpc_pkg::entry_t          ins_entry,
  output mnpc_pkg::entry_t          entry
);
  import mnpc_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   hit;

  assign hit = (cell_idx == ctl.pos);

  always_comb begin
    case (ctl.op)
      CH_HOLD:      entry_nxt = entry_r;
      CH_WRITE:     entry_nxt = hit ? ins_entry : entry_r;
      CH_SHIFT_INS: entry_nxt = hit ? ins_entry : nbr_entry;
      CH_SHIFT:     entry_nxt = nbr_entry;
      default:      entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> hw/rtl/mnpc_chain.sv
// ----------------------------------------------------------------------------
// mnpc_chain
// Row of open-note cells, oldest entry at the head (cell zero).
// ----------------------------------------------------------------------------
module mnpc_chain (
  input  logic                 clk,
  input  mnpc_pkg::chain_ctl_t ctl,
  input  mnpc_pkg::entry_t     ins_entry,
  output mnpc_pkg::entry_t     head_entry
);
  import mnpc_pkg::*;

  entry_t cells [OPEN_SLOTS];
  entry_t nbrs  [OPEN_SLOTS];

  for (genvar i = 0; i < OPEN_SLOTS; i++) begin : g_cell
    if (i == OPEN_SLOTS - 1) begin : g_last
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = cells[i+1];
    end
    mnpc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (SLOT_W'(i)),
      .nbr_entry (nbrs[i]),
      .ins_entry (ins_entry),
      .entry     (cells[i])
    );
  end

  assign head_entry = cells[0];

endmodule

>>> hw/rtl/midi_note_pair_capture_unit.sv
// ----------------------------------------------------------------------------
// midi_note_pair_capture_unit
// Pairs MIDI note-on and note-off events into finished notes for one take.
// ----------------------------------------------------------------------------
// Usage: an input transaction is taken on a rising edge with start high and
// busy low. Note-on, clear, transport without a stop, and ignored items leave
// busy low, so another item may follow at once.
// A note-off scans the open-note chain: the chain rotates one cell per cycle,
// so the scan visits every open note (up to 64) and the oldest matching note
// is emitted while under the capture limit. An all-notes-off or a transport
// stop pops the chain head once per cycle, emitting one note per cycle until
// the run ends or the capture limit is reached. The cost in every case is set
// by the single head port of the chain, which is read once a cycle.
// Results are registered and appear in the cycle after they are computed, each
// on out_data for exactly one cycle with out_valid high; the receiver cannot
// stall them, so every result transaction is taken on that edge. The last
// note of a run has last_of_run set.
// Configuration transactions on the cfg_ channel are always ready and take
// effect on the next edge; the user must write them only while the unit is idle, which the unit does not enforce.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// open-note table, zeroes the take counts and origin and forgets transport.
// ----------------------------------------------------------------------------
module midi_note_pair_capture_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mnpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output mnpc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import mnpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_FLUSH
  } state_t;

  // Configuration registers.
  logic             cap_en_r;
  logic             new_take_play_r;
  logic [6:0]       zone_lo_r;
  logic [6:0]       zone_hi_r;
  logic [31:0]      rewind_thr_r;
  logic [CNT_W-1:0] cap_limit_r;

  // Take and scan state.
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] tail_r, tail_nxt;
  logic [COUNT_W-1:0] steps_r, steps_nxt;
  logic               found_r, found_nxt;
  logic [4:0]         key_ch_r, key_ch_nxt;
  logic [6:0]         key_note_r, key_note_nxt;
  logic [TIME_W-1:0]  off_time_r, off_time_nxt;
  logic [CNT_W-1:0]   captured_r, captured_nxt;
  logic [CNT_W-1:0]   zone_cnt_r, zone_cnt_nxt;
  logic [TIME_W-1:0]  origin_r, origin_nxt;
  logic               was_playing_r, was_playing_nxt;
  logic [TIME_W-1:0]  prev_end_r, prev_end_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  chain_ctl_t ctl;
  entry_t     ins_entry;
  entry_t     head;

  mnpc_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .ins_entry  (ins_entry),
    .head_entry (head)
  );

  // Input decode.
  logic       accept;
  logic [4:0] ch_clamped;
  logic       note_ok;
  logic       rewind;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_data.midi_channel < 5'd1) begin
      ch_clamped = 5'd1;
    end else if (in_data.midi_channel > 5'd16) begin
      ch_clamped = 5'd16;
    end else begin
      ch_clamped = in_data.midi_channel;
    end
  end

  assign note_ok = cap_en_r && was_playing_r;
  assign rewind  = have_prev_r && (prev_end_r >= rewind_thr_r) &&
                   (in_data.event_time < (prev_end_r - rewind_thr_r));

  // Result computation for the note at the chain head.
  logic [6:0]        z_lo, z_hi;
  logic              head_zone;
  logic [TIME_W-1:0] onset_v, rel_v;
  logic              limit_ok;
  logic [CNT_W-1:0]  cap_inc, zone_inc;
  out_item_t         res;

  always_comb begin
    if (zone_lo_r > zone_hi_r) begin
      z_lo = zone_hi_r;
      z_hi = zone_lo_r;
    end else begin
      z_lo = zone_lo_r;
      z_hi = zone_hi_r;
    end
    head_zone = (head.note >= z_lo) && (head.note <= z_hi);
    onset_v = (head.on_time >= origin_r) ? (head.on_time - origin_r) : '0;
    rel_v   = (off_time_r >= origin_r) ? (off_time_r - origin_r) : '0;
    // With both differences clamped at zero, release can fall below onset only
    // when the off time precedes the on time.
    if (off_time_r < head.on_time) begin
      rel_v = onset_v;
    end
    cap_inc  = captured_r + CNT_W'(1);
    zone_inc = head_zone ? (zone_cnt_r + CNT_W'(1)) : zone_cnt_r;
    res.out_channel       = head.channel;
    res.out_note          = head.note;
    res.out_velocity      = head.velocity;
    res.onset             = 32'(onset_v);
    res.release_res       = 32'(rel_v);
    res.in_zone           = head_zone;
    res.notes_so_far      = cap_inc;
    res.zone_notes_so_far = zone_inc;
    res.last_of_run       = 1'b1;
  end

  assign limit_ok = (captured_r < cap_limit_r);

  // Main next-state logic.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    tail_nxt        = tail_r;
    steps_nxt       = steps_r;
    found_nxt       = found_r;
    key_ch_nxt      = key_ch_r;
    key_note_nxt    = key_note_r;
    off_time_nxt    = off_time_r;
    captured_nxt    = captured_r;
    zone_cnt_nxt    = zone_cnt_r;
    origin_nxt      = origin_r;
    was_playing_nxt = was_playing_r;
    prev_end_nxt    = prev_end_r;
    have_prev_nxt   = have_prev_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    ctl.op          = CH_HOLD;
    ctl.pos         = '0;
    ins_entry       = head;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FN_TRANSPORT: begin
              if (cap_en_r) begin
                if ((in_data.is_playing && !was_playing_r && new_take_play_r) ||
                    (in_data.is_playing && was_playing_r && rewind)) begin
                  count_nxt    = '0;
                  captured_nxt = '0;
                  zone_cnt_nxt = '0;
                  origin_nxt   = in_data.event_time;
                end
                if (!in_data.is_playing && was_playing_r) begin
                  off_time_nxt = have_prev_r ? prev_end_r : origin_r;
                  steps_nxt    = count_r;
                  count_nxt    = '0;
                  state_nxt    = S_FLUSH;
                end
              end
              was_playing_nxt = in_data.is_playing;
              prev_end_nxt    = in_data.block_end_time;
              have_prev_nxt   = 1'b1;
            end
            FN_CLEAR: begin
              if (cap_en_r) begin
                count_nxt    = '0;
                captured_nxt = '0;
                zone_cnt_nxt = '0;
                origin_nxt   = in_data.event_time;
              end
            end
            FN_NOTE_ON, FN_NOTE_OFF: begin
              if (note_ok) begin
                if (in_data.func == FN_NOTE_ON && in_data.note_velocity != 7'd0) begin
                  ins_entry.channel  = ch_clamped;
                  ins_entry.note     = in_data.note_number;
                  ins_entry.velocity = in_data.note_velocity;
                  ins_entry.on_time  = in_data.event_time;
                  if (count_r == COUNT_W'(OPEN_SLOTS)) begin
                    // Full: the oldest note falls off the head.
                    ctl.op  = CH_SHIFT_INS;
                    ctl.pos = SLOT_W'(OPEN_SLOTS - 1);
                  end else begin
                    ctl.op    = CH_WRITE;
                    ctl.pos   = count_r[SLOT_W-1:0];
                    count_nxt = count_r + COUNT_W'(1);
                  end
                end else if (count_r != '0) begin
                  key_ch_nxt   = ch_clamped;
                  key_note_nxt = in_data.note_number;
                  off_time_nxt = in_data.event_time;
                  steps_nxt    = count_r;
                  tail_nxt     = count_r;
                  found_nxt    = 1'b0;
                  state_nxt    = S_MATCH;
                end
              end
            end
            FN_ALL_OFF: begin
              if (note_ok) begin
                off_time_nxt = in_data.event_time;
                steps_nxt    = count_r;
                count_nxt    = '0;
                state_nxt    = S_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MATCH: begin
        // Rotate the queue once around; the first match is dropped instead
        // of being reinserted at the tail.
        if (!found_r && head.channel == key_ch_r && head.note == key_note_r) begin
          ctl.op    = CH_SHIFT;
          found_nxt = 1'b1;
          tail_nxt  = tail_r - COUNT_W'(1);
          count_nxt = count_r - COUNT_W'(1);
          if (limit_ok) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
            captured_nxt  = cap_inc;
            zone_cnt_nxt  = zone_inc;
          end
        end else begin
          ctl.op  = CH_SHIFT_INS;
          ctl.pos = SLOT_W'(tail_r - COUNT_W'(1));
        end
        steps_nxt = steps_r - COUNT_W'(1);
        if (steps_r == COUNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (steps_r == '0 || !limit_ok) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.op        = CH_SHIFT;
          out_valid_nxt = 1'b1;
          out_data_nxt  = res;
          out_data_nxt.last_of_run = (steps_r == COUNT_W'(1)) ||
                                     ({1'b0, cap_inc} == {1'b0, cap_limit_r});
          captured_nxt  = cap_inc;
          zone_cnt_nxt  = zone_inc;
          steps_nxt     = steps_r - COUNT_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      tail_r        <= '0;
      steps_r       <= '0;
      found_r       <= 1'b0;
      captured_r    <= '0;
      zone_cnt_r    <= '0;
      origin_r      <= '0;
      was_playing_r <= 1'b0;
      prev_end_r    <= '0;
      have_prev_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      tail_r        <= tail_nxt;
      steps_r       <= steps_nxt;
      found_r       <= found_nxt;
      captured_r    <= captured_nxt;
      zone_cnt_r    <= zone_cnt_nxt;
      origin_r      <= origin_nxt;
      was_playing_r <= was_playing_nxt;
      prev_end_r    <= prev_end_nxt;
      have_prev_r   <= have_prev_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    key_ch_r   <= key_ch_nxt;
    key_note_r <= key_note_nxt;
    off_time_r <= off_time_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r        <= 1'b1;
      new_take_play_r <= 1'b1;
      zone_lo_r       <= 7'd12;
      zone_hi_r       <= 7'd23;
      rewind_thr_r    <= 32'd32768;
      cap_limit_r     <= CNT_W'(200000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPTURE_ENABLE:   cap_en_r        <= cfg_data[0];
        REG_NEW_TAKE_ON_PLAY: new_take_play_r <= cfg_data[0];
        REG_ZONE_LOW:         zone_lo_r       <= cfg_data[6:0];
        REG_ZONE_HIGH:        zone_hi_r       <= cfg_data[6:0];
        REG_REWIND_THRESHOLD: rewind_thr_r    <= cfg_data;
        REG_CAPTURE_LIMIT:    cap_limit_r     <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(OPEN_SLOTS))
    else $error("open count exceeds the table size");

  a_release_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.release_res >= out_data.onset)
    else $error("release precedes onset");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.notes_so_far != '0 &&
                   out_data.zone_notes_so_far <= out_data.notes_so_far))
    else $error("note counts inconsistent");

  a_match_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MATCH && found_r) |-> !out_valid_nxt)
    else $error("second result in one note-off scan");
`endif

endmodule

>>> bench/midi_note_pair_capture_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// midi_note_pair_capture_checker
// Watches the input, result and register channels of the note pair capture
// unit. It keeps its own open-note table and take state, predicts the
// finished notes of every accepted transaction, and compares each result.
// ============================================================================
module midi_note_pair_capture_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  mnpc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  mnpc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  failures,
  output int                  notes_pending,
  output int                  notes_checked
);
  import mnpc_pkg::*;

  // Register copies.
  logic              enable_q;
  logic              take_on_play_q;
  logic [6:0]        zone_a_q, zone_b_q;
  logic [31:0]       rewind_q;
  logic [CNT_W-1:0]  limit_q;

  // Take state.
  entry_t            open_notes [OPEN_SLOTS];
  int                open_total;
  logic [CNT_W-1:0]  captured, zone_captured;
  logic [31:0]       origin, last_block_end;
  logic              playing_q, have_end;

  out_item_t         expected_notes [$];

  assign notes_pending = expected_notes.size();

  task automatic restore_defaults();
    enable_q = 1'b1; take_on_play_q = 1'b1;
    zone_a_q = 7'd12; zone_b_q = 7'd23;
    rewind_q = 32'd32768; limit_q = 18'd200000;
    open_total = 0; captured = '0; zone_captured = '0; origin = '0;
    playing_q = 1'b0; last_block_end = '0; have_end = 1'b0;
    expected_notes.delete();
  endtask

  task automatic begin_take(input logic [31:0] at);
    open_total = 0; captured = '0; zone_captured = '0; origin = at;
  endtask

  task automatic close_note(input entry_t e, input logic [31:0] off_abs);
    out_item_t   r;
    logic [6:0]  lo, hi;
    logic [31:0] rel;
    lo = (zone_a_q > zone_b_q) ? zone_b_q : zone_a_q;
    hi = (zone_a_q > zone_b_q) ? zone_a_q : zone_b_q;
    r = '0;
    r.out_channel  = e.channel;
    r.out_note     = e.note;
    r.out_velocity = e.velocity;
    r.onset        = (e.on_time >= origin) ? e.on_time - origin : '0;
    rel            = (off_abs >= origin) ? off_abs - origin : '0;
    r.release_res  = (rel < r.onset) ? r.onset : rel;
    r.in_zone      = (e.note >= lo) && (e.note <= hi);
    captured       = captured + 1'b1;
    if (r.in_zone) zone_captured = zone_captured + 1'b1;
    r.notes_so_far      = captured;
    r.zone_notes_so_far = zone_captured;
    expected_notes.insert(expected_notes.size(), r);
  endtask

  // Emits every open note oldest first until the limit, then drops the rest.
  task automatic flush_all(input logic [31:0] off_abs);
    int emitted;
    emitted = 0;
    for (int i = 0; i < open_total; i++) begin
      if (captured >= limit_q) break;
      close_note(open_notes[i], off_abs);
      emitted++;
    end
    open_total = 0;
    if (emitted > 0) expected_notes[expected_notes.size()-1].last_of_run = 1'b1;
  endtask

  task automatic predict_notes(input in_item_t it);
    logic [4:0] ch;
    logic       new_take;
    ch = it.midi_channel;
    if (ch < 5'd1) ch = 5'd1;
    if (ch > 5'd16) ch = 5'd16;
    if (it.func == FN_TRANSPORT) begin
      if (enable_q) begin
        new_take = 1'b0;
        if (it.is_playing && !playing_q)
          new_take = take_on_play_q;
        else if (it.is_playing && playing_q && have_end && last_block_end >= rewind_q
                 && it.event_time < last_block_end - rewind_q)
          new_take = 1'b1;
        if (new_take) begin_take(it.event_time);
        if (!it.is_playing && playing_q)
          flush_all(have_end ? last_block_end : origin);
      end
      playing_q = it.is_playing;
      last_block_end = it.block_end_time;
      have_end = 1'b1;
    end else if (it.func == FN_CLEAR) begin
      if (enable_q) begin_take(it.event_time);
    end else if (enable_q && playing_q && it.func <= FN_ALL_OFF) begin
      if (it.func == FN_NOTE_ON && it.note_velocity != 0) begin
        if (open_total >= OPEN_SLOTS) begin
          for (int i = 0; i < OPEN_SLOTS - 1; i++) open_notes[i] = open_notes[i+1];
          open_total = OPEN_SLOTS - 1;
        end
        open_notes[open_total] = '{channel: ch, note: it.note_number,
                                   velocity: it.note_velocity, on_time: it.event_time};
        open_total++;
      end else if (it.func == FN_ALL_OFF) begin
        flush_all(it.event_time);
      end else begin
        // Note-off, or note-on at velocity zero: oldest match only.
        for (int i = 0; i < open_total; i++) begin
          if (open_notes[i].channel == ch && open_notes[i].note == it.note_number) begin
            if (captured < limit_q) begin
              close_note(open_notes[i], it.event_time);
              expected_notes[expected_notes.size()-1].last_of_run = 1'b1;
            end
            for (int j = i; j < open_total - 1; j++) open_notes[j] = open_notes[j+1];
            open_total--;
            break;
          end
        end
      end
    end
  endtask

  function automatic int field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        ok;
    if (!rst_n) begin
      restore_defaults();
      failures      <= 0;
      notes_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAPTURE_ENABLE:   enable_q       = cfg_data[0];
          REG_NEW_TAKE_ON_PLAY: take_on_play_q = cfg_data[0];
          REG_ZONE_LOW:         zone_a_q       = cfg_data[6:0];
          REG_ZONE_HIGH:        zone_b_q       = cfg_data[6:0];
          REG_REWIND_THRESHOLD: rewind_q       = cfg_data;
          REG_CAPTURE_LIMIT:    limit_q        = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_notes(in_data);
      if (out_valid) begin
        notes_checked <= notes_checked + 1;
        if (expected_notes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
          failures <= failures + 1;
        end else begin
          want = expected_notes.pop_front();
          ok = field_ok("out_channel", want.out_channel, out_data.out_channel)
             & field_ok("out_note", want.out_note, out_data.out_note)
             & field_ok("out_velocity", want.out_velocity, out_data.out_velocity)
             & field_ok("onset", want.onset, out_data.onset)
             & field_ok("release_res", want.release_res, out_data.release_res)
             & field_ok("in_zone", want.in_zone, out_data.in_zone)
             & field_ok("notes_so_far", want.notes_so_far, out_data.notes_so_far)
             & field_ok("zone_notes_so_far", want.zone_notes_so_far,
                        out_data.zone_notes_so_far)
             & field_ok("last_of_run", want.last_of_run, out_data.last_of_run);
          if (!ok) failures <= failures + 1;
        end
      end
    end
  end

endmodule

>>> bench/midi_note_pair_capture_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// midi_note_pair_capture_unit_tb
// Drives note, all-notes-off, transport, clear and unused transactions into
// the capture unit under several register settings, with random gaps, while
// the checker predicts and compares every finished note.
// ============================================================================
module midi_note_pair_capture_unit_tb;
  import mnpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // A note-off scan can run over the whole 64-entry chain with no result.
  localparam int SETTLE_CYCLES = 80;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int          failures, notes_pending, notes_checked;
  int          cycles;
  int          sent;
  // Running song position; most events move forward from it.
  logic [31:0] song_pos;

  midi_note_pair_capture_unit dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  midi_note_pair_capture_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .failures, .notes_pending, .notes_checked
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("midi_note_pair_capture_unit_tb: errors");
      $finish;
    end
  end

  // Presents one transaction after a random gap and holds it until the unit
  // takes it. Start stays high when the next transaction follows at once.
  task automatic send_event(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  function automatic in_item_t note_event(input logic [2:0] fn, input logic [4:0] ch,
                                          input logic [6:0] nt, input logic [6:0] vel,
                                          input logic [31:0] at);
    in_item_t it;
    it = '0;
    it.func = fn; it.midi_channel = ch; it.note_number = nt;
    it.note_velocity = vel; it.event_time = at;
    // Fields that the function ignores still carry noise.
    it.block_end_time = $urandom;
    it.is_playing = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t transport_event(input logic [31:0] from,
                                               input logic [31:0] upto,
                                               input logic playing);
    in_item_t it;
    it = note_event(FN_TRANSPORT, 5'($urandom), 7'($urandom), 7'($urandom), from);
    it.block_end_time = upto;
    it.is_playing = playing;
    return it;
  endfunction

  // Waits until every predicted note has come out and the unit has gone
  // quiet, so that registers can be written safely.
  task automatic settle();
    start = 1'b0;
    do @(posedge clk); while (notes_pending != 0 || busy);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic play_block();
    logic [31:0] from;
    from = song_pos;
    song_pos = song_pos + $urandom_range(1, 32'h8000);
    send_event(transport_event(from, song_pos, 1'b1));
  endtask

  // One random session: mostly a well-formed performance on a few keys so
  // that note-offs find their notes, with noise and odd transport mixed in.
  task automatic perform(input int count);
    int          pick;
    logic [4:0]  ch;
    logic [6:0]  nt;
    logic [31:0] at;
    logic [31:0] from;
    play_block();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      ch = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 3));
      nt = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(10, 25));
      song_pos = song_pos + $urandom_range(0, 32'h4000);
      at = ($urandom_range(0, 19) == 0) ? 32'($urandom) : song_pos;
      if (pick < 45) begin
        send_event(note_event(FN_NOTE_ON, ch, nt,
                   ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127)), at));
      end else if (pick < 75) begin
        if ($urandom_range(0, 4) == 0)
          send_event(note_event(FN_NOTE_ON, ch, nt, 7'd0, at));
        else
          send_event(note_event(FN_NOTE_OFF, ch, nt, 7'($urandom), at));
      end else if (pick < 80) begin
        send_event(note_event(FN_ALL_OFF, ch, nt, 7'($urandom), at));
      end else if (pick < 91) begin
        // Forward block, occasional backward jump, occasional stop.
        from = ($urandom_range(0, 3) == 0) ? song_pos - $urandom_range(0, 32'h40000)
                                           : song_pos;
        if ($urandom_range(0, 19) == 0) from = $urandom;
        song_pos = from + $urandom_range(1, 32'h8000);
        send_event(transport_event(from, song_pos, $urandom_range(0, 3) != 0));
      end else if (pick < 94) begin
        send_event(note_event(FN_CLEAR, ch, nt, 7'($urandom), at));
      end else if (pick < 96) begin
        send_event(note_event(3'($urandom_range(5, 7)), ch, nt, 7'($urandom), at));
      end else begin
        send_event(note_event(3'($urandom), 5'($urandom), 7'($urandom), 7'($urandom),
                              $urandom));
      end
    end
  endtask

  initial begin
    cycles = 0; sent = 0;
    song_pos = 32'h0001_0000;
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = REG_CAPTURE_ENABLE; cfg_data = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset settings.
    send_event(note_event(FN_NOTE_ON, 5'd1, 7'd60, 7'd100, 32'h100));  // ignored, stopped
    play_block();
    send_event(note_event(FN_NOTE_ON, 5'd0, 7'd0, 7'd1, 32'h0));        // channel clamps to 1
    send_event(note_event(FN_NOTE_ON, 5'd31, 7'd127, 7'd127, 32'hFFFF_FFFF));
    send_event(note_event(FN_NOTE_ON, 5'd16, 7'd12, 7'd64, song_pos));
    send_event(note_event(FN_NOTE_ON, 5'd16, 7'd12, 7'd65, song_pos + 1));
    send_event(note_event(FN_NOTE_OFF, 5'd16, 7'd12, 7'd0, song_pos + 5));   // oldest match
    send_event(note_event(FN_NOTE_ON, 5'd1, 7'd0, 7'd0, 32'h0));        // velocity zero off
    send_event(note_event(FN_NOTE_OFF, 5'd31, 7'd127, 7'd127, 32'h0));  // off before onset
    send_event(note_event(FN_NOTE_OFF, 5'd5, 7'd50, 7'd9, song_pos));   // unmatched
    send_event(note_event(3'd5, 5'd1, 7'd12, 7'd1, 32'h1));
    send_event(note_event(3'd7, 5'd1, 7'd12, 7'd1, 32'h1));
    send_event(note_event(FN_NOTE_ON, 5'd2, 7'd23, 7'd3, song_pos));
    send_event(note_event(FN_NOTE_ON, 5'd17, 7'd24, 7'd4, song_pos));
    send_event(note_event(FN_ALL_OFF, 5'd0, 7'd0, 7'd0, song_pos + 32'h100));
    send_event(note_event(FN_NOTE_ON, 5'd3, 7'd11, 7'd5, song_pos));
    send_event(transport_event(song_pos, song_pos + 32'h1000, 1'b0));  // stop flushes
    play_block();
    send_event(note_event(FN_NOTE_ON, 5'd4, 7'd40, 7'd6, song_pos));
    send_event(transport_event(32'h0, 32'h10, 1'b1));                   // rewind
    send_event(note_event(FN_NOTE_ON, 5'd4, 7'd41, 7'd7, 32'h8));
    send_event(note_event(FN_CLEAR, 5'd0, 7'd0, 7'd0, 32'h20));
    send_event(note_event(FN_NOTE_OFF, 5'd4, 7'd41, 7'd0, 32'h30));
    settle();

    // A full table evicts its oldest notes; the flush then emits 64 notes.
    play_block();
    repeat (70) begin
      song_pos = song_pos + $urandom_range(0, 32'h100);
      send_event(note_event(FN_NOTE_ON, 5'($urandom_range(1, 16)), 7'($urandom),
                            7'($urandom_range(1, 127)), song_pos));
    end
    send_event(note_event(FN_ALL_OFF, 5'd1, 7'd0, 7'd0, song_pos));
    perform(40);
    settle();

    // Small capture limit, reversed zone, no new take on play, zero threshold.
    write_register(REG_CAPTURE_LIMIT, 32'd4);
    write_register(REG_ZONE_LOW, 32'd20);
    write_register(REG_ZONE_HIGH, 32'd14);
    write_register(REG_NEW_TAKE_ON_PLAY, 32'd0);
    write_register(REG_REWIND_THRESHOLD, 32'd0);
    perform(80);
    settle();

    // Capture off: notes, flushes and clears are dropped, transport tracked.
    write_register(REG_CAPTURE_ENABLE, 32'd0);
    perform(30);
    settle();

    // Extremes of every register.
    write_register(REG_CAPTURE_ENABLE, 32'd1);
    write_register(REG_NEW_TAKE_ON_PLAY, 32'd1);
    write_register(REG_ZONE_LOW, 32'd0);
    write_register(REG_ZONE_HIGH, 32'd127);
    write_register(REG_REWIND_THRESHOLD, 32'hFFFF_FFFF);
    write_register(REG_CAPTURE_LIMIT, 32'h3FFFF);
    perform(80);
    settle();

    write_register(REG_CAPTURE_LIMIT, 32'd0);
    write_register(REG_ZONE_LOW, 32'd127);
    write_register(REG_ZONE_HIGH, 32'd0);
    write_register(REG_REWIND_THRESHOLD, 32'h0000_1000);
    perform(20);
    settle();

    write_register(REG_CAPTURE_LIMIT, 32'd200000);
    write_register(REG_ZONE_LOW, 32'd12);
    write_register(REG_ZONE_HIGH, 32'd23);
    perform(60);
    settle();

    $display("Sent %0d transactions over six register settings; %0d notes checked.",
             sent, notes_checked);
    if (failures == 0)
      $display("midi_note_pair_capture_unit_tb: clean");
    else
      $display("midi_note_pair_capture_unit_tb: errors");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mnpc_pkg.sv
hw/rtl/mnpc_cell.sv
hw/rtl/mnpc_chain.sv
hw/rtl/midi_note_pair_capture_unit.sv
bench/midi_note_pair_capture_checker.sv
bench/midi_note_pair_capture_unit_tb.sv
